>>> src/strs_pkg.sv
// Shared constants, types and codes for the sparse table range spread unit.
package strs_pkg;

    localparam int DEPTH      = 4096;
    localparam int LEVELS     = 13;
    localparam int VALUE_BITS = 20;

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int SPAN_W    = CNT_W + 1;
    localparam int MEM_DEPTH = LEVELS * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int OP_W    = 2;
    localparam int IDX_FW  = 12;
    localparam int VAL_FW  = 20;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 64;

    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [LVL_W-1:0]      lvl_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    function automatic addr_t mem_addr(input lvl_t lvl, input idx_t idx);
        mem_addr = ADDR_W'({lvl, idx});
    endfunction

endpackage

>>> src/sparse_table_range_spread_unit.sv
// Sparse table range max/min/spread unit with append, query and restart words.
// Append at position p writes level 0, then one level per cycle up to min(floor(log2(p+1)),
// LEVELS-1), through the single read port of each table. Restart clears the count.
// Query: block reads on accept and in S_QA, merge in S_QB, result registered in S_QOUT (bad range: S_QOUT only).
// One input word is in work at a time; a query result waits in the output register.
// Reset clears control and count only; the tables are never cleared.
module sparse_table_range_spread_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [strs_pkg::IN_W-1:0]   s_tdata,  // op[1:0] value[21:2] left[33:22] right[45:34]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [strs_pkg::OUT_W-1:0]  m_tdata   // spread[19:0] range_max[39:20] range_min[59:40] bad_range[60]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_APP  = 3'd1;
    localparam logic [2:0] S_QA   = 3'd2;
    localparam logic [2:0] S_QB   = 3'd3;
    localparam logic [2:0] S_QOUT = 3'd4;

    logic [2:0] state_reg, state_next;
    strs_pkg::cnt_t cnt_reg, cnt_next;
    strs_pkg::idx_t pos_reg, pos_next;
    strs_pkg::lvl_t lvl_reg, lvl_next;
    strs_pkg::value_t cur_max_reg, cur_max_next, cur_min_reg, cur_min_next;
    strs_pkg::idx_t sec_reg, sec_next;
    strs_pkg::value_t res_max_reg, res_max_next, res_min_reg, res_min_next;
    logic res_bad_reg, res_bad_next;
    logic out_valid_reg, out_valid_next;
    logic [strs_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    strs_pkg::value_t max_mem [0:strs_pkg::MEM_DEPTH-1];
    strs_pkg::value_t min_mem [0:strs_pkg::MEM_DEPTH-1];
    strs_pkg::value_t max_rd, min_rd;
    logic we, re;
    strs_pkg::addr_t waddr, raddr;
    strs_pkg::value_t wmax, wmin;

    logic [strs_pkg::OP_W-1:0] in_op;
    strs_pkg::value_t in_value;
    strs_pkg::idx_t in_left, in_right;
    logic accept;

    strs_pkg::cnt_t q_len;
    strs_pkg::lvl_t q_lvl;
    logic q_bad;
    logic [strs_pkg::SPAN_W-1:0] q_second;

    logic [strs_pkg::SPAN_W-1:0] pos_p1, span_cur, span_nxt, start_cur, start_nxt;
    logic [strs_pkg::LVL_W:0] lvl_nxt;
    logic more;
    strs_pkg::value_t new_max, new_min;

    function automatic strs_pkg::lvl_t floor_log2(input strs_pkg::cnt_t x);
        strs_pkg::lvl_t s;
        s = '0;
        for (int i = 0; i < strs_pkg::CNT_W; i++)
        begin
            if (x[i])
            begin
                s = strs_pkg::LVL_W'(i);
            end
        end
        if (s > strs_pkg::LVL_W'(strs_pkg::LEVELS - 1))
        begin
            s = strs_pkg::LVL_W'(strs_pkg::LEVELS - 1);
        end
        floor_log2 = s;
    endfunction

    assign in_op    = s_tdata[1:0];
    assign in_value = strs_pkg::VALUE_BITS'(s_tdata[21:2]);
    assign in_left  = strs_pkg::IDX_W'(s_tdata[33:22]);
    assign in_right = strs_pkg::IDX_W'(s_tdata[45:34]);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // query decode
    assign q_bad    = (in_left > in_right) || (strs_pkg::CNT_W'(in_right) >= cnt_reg);
    assign q_len    = strs_pkg::CNT_W'(in_right) - strs_pkg::CNT_W'(in_left)
                      + strs_pkg::CNT_W'(1);
    assign q_lvl    = floor_log2(q_len);
    assign q_second = strs_pkg::SPAN_W'(in_right) + strs_pkg::SPAN_W'(1)
                      - (strs_pkg::SPAN_W'(1) << q_lvl);

    // append level walk
    assign pos_p1    = strs_pkg::SPAN_W'(pos_reg) + strs_pkg::SPAN_W'(1);
    assign span_cur  = strs_pkg::SPAN_W'(1) << lvl_reg;
    assign start_cur = pos_p1 - span_cur;
    assign lvl_nxt   = {1'b0, lvl_reg} + (strs_pkg::LVL_W + 1)'(1);
    assign span_nxt  = strs_pkg::SPAN_W'(1) << lvl_nxt;
    assign start_nxt = pos_p1 - span_nxt;
    assign more      = (lvl_nxt < (strs_pkg::LVL_W + 1)'(strs_pkg::LEVELS))
                       && (pos_p1 >= span_nxt);
    assign new_max   = (max_rd > cur_max_reg) ? max_rd : cur_max_reg;
    assign new_min   = (min_rd < cur_min_reg) ? min_rd : cur_min_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        lvl_next       = lvl_reg;
        cur_max_next   = cur_max_reg;
        cur_min_next   = cur_min_reg;
        sec_next       = sec_reg;
        res_max_next   = res_max_reg;
        res_min_next   = res_min_reg;
        res_bad_next   = res_bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        we    = 1'b0;
        re    = 1'b0;
        waddr = '0;
        raddr = '0;
        wmax  = cur_max_reg;
        wmin  = cur_min_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == strs_pkg::OP_APPEND)
                    begin
                        if (cnt_reg < strs_pkg::CNT_W'(strs_pkg::DEPTH))
                        begin
                            we           = 1'b1;
                            waddr        = strs_pkg::mem_addr('0, cnt_reg[strs_pkg::IDX_W-1:0]);
                            wmax         = in_value;
                            wmin         = in_value;
                            cur_max_next = in_value;
                            cur_min_next = in_value;
                            pos_next     = cnt_reg[strs_pkg::IDX_W-1:0];
                            lvl_next     = strs_pkg::LVL_W'(1);
                            cnt_next     = cnt_reg + strs_pkg::CNT_W'(1);
                            if (cnt_reg != '0 && strs_pkg::LEVELS > 1)
                            begin
                                re         = 1'b1;
                                raddr      = strs_pkg::mem_addr('0,
                                    cnt_reg[strs_pkg::IDX_W-1:0] - strs_pkg::IDX_W'(1));
                                state_next = S_APP;
                            end
                        end
                    end
                    else if (in_op == strs_pkg::OP_RESTART)
                    begin
                        cnt_next = '0;
                    end
                    else if (in_op == strs_pkg::OP_QUERY)
                    begin
                        if (q_bad)
                        begin
                            res_bad_next = 1'b1;
                            res_max_next = '0;
                            res_min_next = '0;
                            state_next   = S_QOUT;
                        end
                        else
                        begin
                            res_bad_next = 1'b0;
                            lvl_next     = q_lvl;
                            sec_next     = q_second[strs_pkg::IDX_W-1:0];
                            re           = 1'b1;
                            raddr        = strs_pkg::mem_addr(q_lvl, in_left);
                            state_next   = S_QA;
                        end
                    end
                end
            end
            S_APP:
            begin
                we           = 1'b1;
                waddr        = strs_pkg::mem_addr(lvl_reg, start_cur[strs_pkg::IDX_W-1:0]);
                wmax         = new_max;
                wmin         = new_min;
                cur_max_next = new_max;
                cur_min_next = new_min;
                if (more)
                begin
                    re         = 1'b1;
                    raddr      = strs_pkg::mem_addr(lvl_reg, start_nxt[strs_pkg::IDX_W-1:0]);
                    lvl_next   = lvl_nxt[strs_pkg::LVL_W-1:0];
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_QA:
            begin
                cur_max_next = max_rd;
                cur_min_next = min_rd;
                re           = 1'b1;
                raddr        = strs_pkg::mem_addr(lvl_reg, sec_reg);
                state_next   = S_QB;
            end
            S_QB:
            begin
                res_max_next = new_max;
                res_min_next = new_min;
                state_next   = S_QOUT;
            end
            S_QOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[19:0]  = 20'(res_max_reg - res_min_reg);
                    out_data_next[39:20] = 20'(res_max_reg);
                    out_data_next[59:40] = 20'(res_min_reg);
                    out_data_next[60]    = res_bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        lvl_reg      <= lvl_next;
        cur_max_reg  <= cur_max_next;
        cur_min_reg  <= cur_min_next;
        sec_reg      <= sec_next;
        res_max_reg  <= res_max_next;
        res_min_reg  <= res_min_next;
        res_bad_reg  <= res_bad_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            max_mem[waddr] <= wmax;
        end
        if (re)
        begin
            max_rd <= max_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            min_mem[waddr] <= wmin;
        end
        if (re)
        begin
            min_rd <= min_mem[raddr];
        end
    end

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[60] |-> m_tdata[59:0] == '0)
        else $error("bad range word carries nonzero data");

    a_spread: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:0] == 20'(m_tdata[39:20] - m_tdata[59:40]))
        else $error("spread differs from max minus min");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[60] |-> m_tdata[39:20] >= m_tdata[59:40])
        else $error("range max below range min");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= strs_pkg::CNT_W'(strs_pkg::DEPTH))
        else $error("loaded count beyond depth");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APP |-> !s_tready && $past(cnt_reg) != '0 || state_reg != S_APP)
        else $error("append walk with ready high");

endmodule
